[rtl/core/double_ended_queue_defines.svh]
// assertion macros for the deque checker
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dq_pkg.sv]
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;
  localparam int WORD_W = 32;

  // request codes
  localparam logic [1:0] FUNC_INS_REAR  = 2'd0;
  localparam logic [1:0] FUNC_INS_FRONT = 2'd1;
  localparam logic [1:0] FUNC_DEL_REAR  = 2'd2;
  localparam logic [1:0] FUNC_DEL_FRONT = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic exec;      // input transaction accepted this cycle
    logic load_out;  // move finished result into output register
  } dq_cmd_t;

endpackage

[rtl/core/double_ended_queue.sv]
// bounded double-ended queue of signed 32-bit words (16 entries)
// input channel: in_func selects insert rear, insert front, delete rear or
//   delete front; in_value is the word to insert and is ignored for deletes
// result channel: one transaction per request with out_status (done,
//   overflow, underflow), out_removed_value (word taken out, else zero) and
//   out_occupancy (words stored after the request)
// results: status and read word are registered at acceptance, then move
//   into the output register once it is free; no new request is taken
//   until the previous result has moved there; pointers and count are
//   updated at acceptance and the entry store read is registered, so the
//   result is formed in the cycle after acceptance
// stall: the result sits in an output register; while it waits the block
//   still takes the next request, then holds that result internally and
//   keeps in_ready low until the output register frees
// reset: synchronous active-low rst_n empties the queue (head, tail and
//   count to zero) and drops out_valid; stored words are not cleared
module double_ended_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_func,
  input  logic signed [31:0]       in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [31:0]       out_removed_value,
  output logic [dq_pkg::OCC_W-1:0] out_occupancy
);
  import dq_pkg::*;

  // command bundle from controller to datapath
  dq_cmd_t cmd;

  // handshake sequencing and output valid
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // pointers, count, entry store and output register
  dq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_func           (in_func),
    .in_value          (in_value),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_occupancy     (out_occupancy)
  );

endmodule

[rtl/core/dq_ctrl.sv]
module dq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_RESULT = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.exec     = in_valid && in_ready;
  assign cmd.load_out = (state_r == S_RESULT) && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.exec) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/dq_dp.sv]
module dq_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dq_pkg::dq_cmd_t             cmd,
  input  logic [1:0]                  in_func,
  input  logic signed [31:0]          in_value,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_removed_value,
  output logic [dq_pkg::OCC_W-1:0]    out_occupancy
);
  import dq_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [1:0]               stat_r, stat_nxt;
  logic                     take_r, take_nxt;
  logic signed [WORD_W-1:0] rd_data_r;

  logic [1:0]               out_status_r;
  logic signed [WORD_W-1:0] out_removed_r;
  logic [OCC_W-1:0]         out_occ_r;

  logic             full, empty;
  logic             mem_we;
  logic [IDX_W-1:0] waddr, raddr;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    stat_nxt  = STAT_DONE;
    take_nxt  = 1'b0;
    mem_we    = 1'b0;
    waddr     = tail_r;
    raddr     = head_r;
    case (in_func)
      FUNC_INS_REAR: begin
        if (full) begin
          stat_nxt = STAT_OVERFLOW;
        end else begin
          mem_we    = 1'b1;
          waddr     = tail_r;
          tail_nxt  = idx_next(tail_r);
          count_nxt = count_r + 1'b1;
        end
      end
      FUNC_INS_FRONT: begin
        if (full) begin
          stat_nxt = STAT_OVERFLOW;
        end else begin
          mem_we    = 1'b1;
          waddr     = idx_prev(head_r);
          head_nxt  = idx_prev(head_r);
          count_nxt = count_r + 1'b1;
        end
      end
      FUNC_DEL_REAR: begin
        if (empty) begin
          stat_nxt = STAT_UNDERFLOW;
        end else begin
          take_nxt  = 1'b1;
          raddr     = idx_prev(tail_r);
          tail_nxt  = idx_prev(tail_r);
          count_nxt = count_r - 1'b1;
        end
      end
      FUNC_DEL_FRONT: begin
        if (empty) begin
          stat_nxt = STAT_UNDERFLOW;
        end else begin
          take_nxt  = 1'b1;
          raddr     = head_r;
          head_nxt  = idx_next(head_r);
          count_nxt = count_r - 1'b1;
        end
      end
      default: stat_nxt = STAT_DONE;
    endcase
  end

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) mem[waddr] <= in_value;
    if (cmd.exec) rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      stat_r <= stat_nxt;
      take_r <= take_nxt;
    end
    if (cmd.load_out) begin
      out_status_r  <= stat_r;
      out_removed_r <= take_r ? rd_data_r : '0;
      out_occ_r     <= OCC_W'(count_r);
    end
  end

  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_occupancy     = out_occ_r;

endmodule

[rtl/core/dq_checker.sv]
`include "double_ended_queue_defines.svh"

module dq_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               in_func,
  input logic signed [31:0]       in_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               out_status,
  input logic signed [31:0]       out_removed_value,
  input logic [dq_pkg::OCC_W-1:0] out_occupancy
);
  import dq_pkg::*;

  `DQ_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_func) && $stable(in_value), "request changed while waiting")

  `DQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")

  `DQ_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_status) && $stable(out_removed_value) && $stable(out_occupancy), "result changed while stalled")

  `DQ_ASSERT_NOW(a_status_code, out_valid, out_status == STAT_DONE || out_status == STAT_OVERFLOW || out_status == STAT_UNDERFLOW, "illegal status code")

  `DQ_ASSERT_NOW(a_fail_zero, out_valid && out_status != STAT_DONE, out_removed_value == '0 && (out_status == STAT_OVERFLOW ? out_occupancy == OCC_W'(DEPTH) : out_occupancy == '0), "failed request with bad removed word or occupancy")

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
